@@ hdl/tds_pkg.sv @@
// Package for the triangle depth sorter: shared types and constants.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
package tds_pkg;
    localparam int KEY_W = 38;
    localparam int CRD_W = 16;
    localparam int IDX_W = 8;

    localparam logic [1:0] REG_EYE_X = 2'd0;
    localparam logic [1:0] REG_EYE_Y = 2'd1;
    localparam logic [1:0] REG_EYE_Z = 2'd2;
    localparam logic [1:0] REG_B2F   = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_AX, ST_SQ, ST_SUM, ST_STORE,
        ST_SORT_RD, ST_SORT_CMP, ST_SORT_WR, ST_EMIT_RD, ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       vtx_wr;
        logic [1:0] vtx_rd_sel;  // which corner to fetch
        logic       acc_clr;
        logic       sum_stage;   // add the fetched corner into the sums
        logic       sq_stage;
        logic       key_stage;
        logic       tri_wr;
        logic       sort_load;   // read entries at j-1 and j
        logic       sort_swap;
        logic       emit_load;
        logic       emit_show;
        logic       run_clear;
    } t_cmd;

    typedef struct packed {
        logic       tri_full;
        logic       swap_needed;
    } t_stat;
endpackage

@@ hdl/tds_datapath.sv @@
// Datapath of the triangle depth sorter: vertex memory, key arithmetic,
// triangle store and emission registers. Depends on tds_pkg.
`timescale 1ns / 1ps
module tds_datapath #(
    parameter int MAX_TRIANGLES = 64,
    parameter int MAX_VERTICES  = 256,
    parameter int TW = $clog2(MAX_TRIANGLES + 1),
    parameter int TI = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
    input  logic                       i_clk,
    input  tds_pkg::t_cmd              i_cmd,
    input  logic [7:0]                 i_vertex_index,
    input  logic signed [15:0]         i_pos_x,
    input  logic signed [15:0]         i_pos_y,
    input  logic signed [15:0]         i_pos_z,
    input  logic [7:0]                 i_corner_a,
    input  logic [7:0]                 i_corner_b,
    input  logic [7:0]                 i_corner_c,
    input  logic signed [15:0]         i_eye_x,
    input  logic signed [15:0]         i_eye_y,
    input  logic signed [15:0]         i_eye_z,
    input  logic [TW-1:0]              i_count,
    input  logic [TI-1:0]              i_sort_j,
    input  logic [TI-1:0]              i_emit_idx,
    output tds_pkg::t_stat             o_stat,
    output logic [7:0]                 o_a,
    output logic [7:0]                 o_b,
    output logic [7:0]                 o_c
);
    import tds_pkg::*;

    localparam int VI = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int ENT_W = KEY_W + 3 * IDX_W;

    logic [3*CRD_W-1:0] r_vmem [MAX_VERTICES];
    logic [3*CRD_W-1:0] r_vrd;
    logic               r_vok;
    logic [ENT_W-1:0]   r_tmem [MAX_TRIANGLES];
    logic [ENT_W-1:0]   r_e0, r_e1;
    logic signed [18:0] r_dx, r_dy, r_dz;
    logic [37:0]        r_qx, r_qy, r_qz;
    logic [KEY_W-1:0]   r_key;
    logic [7:0]         r_a, r_b, r_c;
    logic [7:0]         rd_idx;
    logic [VI-1:0]      vaddr;
    logic signed [18:0] fx, fy, fz;

    always_comb begin
        case (i_cmd.vtx_rd_sel)
            2'd0:    rd_idx = i_corner_a;
            2'd1:    rd_idx = i_corner_b;
            default: rd_idx = i_corner_c;
        endcase
        vaddr = i_cmd.vtx_wr ? i_vertex_index[VI-1:0] : rd_idx[VI-1:0];
        fx = r_vok ? 19'(signed'(r_vrd[47:32])) : 19'sd0;
        fy = r_vok ? 19'(signed'(r_vrd[31:16])) : 19'sd0;
        fz = r_vok ? 19'(signed'(r_vrd[15:0]))  : 19'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.vtx_wr && (32'(i_vertex_index) < MAX_VERTICES))
            r_vmem[vaddr] <= {i_pos_x, i_pos_y, i_pos_z};
        r_vrd <= r_vmem[vaddr];
        r_vok <= 32'(rd_idx) < MAX_VERTICES;
    end

    // Sums start at -3*eye, then each fetched corner is added.
    always_ff @(posedge i_clk) begin
        if (i_cmd.acc_clr) begin
            r_dx <= -(19'(i_eye_x) * 19'sd3);
            r_dy <= -(19'(i_eye_y) * 19'sd3);
            r_dz <= -(19'(i_eye_z) * 19'sd3);
        end else if (i_cmd.sum_stage) begin
            r_dx <= r_dx + fx;
            r_dy <= r_dy + fy;
            r_dz <= r_dz + fz;
        end
        if (i_cmd.sq_stage) begin
            r_qx <= 38'(r_dx * r_dx);
            r_qy <= 38'(r_dy * r_dy);
            r_qz <= 38'(r_dz * r_dz);
        end
        if (i_cmd.key_stage)
            r_key <= r_qx + r_qy + r_qz;
    end

    logic [TI-1:0] jm1, jm2;
    assign jm1 = i_sort_j - 1'b1;
    assign jm2 = i_sort_j - TI'(2);

    // The entry that moves down stays in r_e1; a swap fetches its next neighbor.
    always_ff @(posedge i_clk) begin
        if (i_cmd.tri_wr)
            r_tmem[i_count[TI-1:0]] <= {r_key, i_corner_a, i_corner_b, i_corner_c};
        else if (i_cmd.sort_swap) begin
            r_tmem[jm1]      <= r_e1;
            r_tmem[i_sort_j] <= r_e0;
        end
        if (i_cmd.sort_load) begin
            r_e0 <= r_tmem[jm1];
            r_e1 <= r_tmem[i_sort_j];
        end
        if (i_cmd.sort_swap)
            r_e0 <= r_tmem[jm2];
        if (i_cmd.emit_load)
            r_e0 <= r_tmem[i_emit_idx];
        if (i_cmd.emit_show)
            {r_a, r_b, r_c} <= r_e0[3*IDX_W-1:0];
    end

    assign o_stat.tri_full    = (32'(i_count) >= MAX_TRIANGLES);
    assign o_stat.swap_needed = r_e0[ENT_W-1 -: KEY_W] > r_e1[ENT_W-1 -: KEY_W];
    assign o_a = r_a;
    assign o_b = r_b;
    assign o_c = r_c;
endmodule

@@ hdl/tds_ctrl.sv @@
// Controller of the triangle depth sorter: sequences key computation,
// insertion sort and emission. Depends on tds_pkg.
`timescale 1ns / 1ps
module tds_ctrl #(
    parameter int MAX_TRIANGLES = 64,
    parameter int TW = $clog2(MAX_TRIANGLES + 1),
    parameter int TI = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_go,
    input  logic            i_req_type,
    input  logic            i_final,
    input  logic            i_b2f,
    input  tds_pkg::t_stat  i_stat,
    output tds_pkg::t_cmd   o_cmd,
    output logic            o_busy,
    output logic [TW-1:0]   o_count,
    output logic [TI-1:0]   o_sort_j,
    output logic [TI-1:0]   o_emit_idx,
    output logic            o_valid,
    output logic            o_run_end,
    output logic            o_dropped
);
    import tds_pkg::*;

    t_state        r_state, n_state;
    logic [TW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_fin, n_fin;
    logic [TW-1:0] r_i, n_i;       // insertion pass / emit counter
    logic [TI-1:0] r_j, n_j;
    logic          r_valid, n_valid, r_end, n_end, r_drop, n_drop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_fin   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_valid <= 1'b0;
            r_end   <= 1'b0;
            r_drop  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_fin   <= n_fin;
            r_i     <= n_i;
            r_j     <= n_j;
            r_valid <= n_valid;
            r_end   <= n_end;
            r_drop  <= n_drop;
        end
    end

    logic [TW-1:0] emit_pos;
    always_comb begin
        emit_pos = i_b2f ? (r_count - 1'b1 - r_i) : r_i;
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ovf   = r_ovf;
        n_fin   = r_fin;
        n_i     = r_i;
        n_j     = r_j;
        n_valid = 1'b0;
        n_end   = 1'b0;
        n_drop  = r_drop;
        o_cmd   = '0;
        o_cmd.vtx_rd_sel = 2'd0;
        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    if (!i_req_type) begin
                        o_cmd.vtx_wr = 1'b1;
                    end else begin
                        n_fin = i_final;
                        o_cmd.acc_clr = 1'b1;
                        n_state = ST_RD_A;
                    end
                end
            end
            ST_RD_A: begin
                o_cmd.vtx_rd_sel = 2'd0;
                n_state = ST_RD_B;
            end
            ST_RD_B: begin
                o_cmd.vtx_rd_sel = 2'd1;
                o_cmd.sum_stage = 1'b1;
                n_state = ST_RD_C;
            end
            ST_RD_C: begin
                o_cmd.vtx_rd_sel = 2'd2;
                o_cmd.sum_stage = 1'b1;
                n_state = ST_AX;
            end
            ST_AX: begin
                o_cmd.sum_stage = 1'b1;
                n_state = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq_stage = 1'b1;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.key_stage = 1'b1;
                n_state = ST_STORE;
            end
            ST_STORE: begin
                if (i_stat.tri_full) begin
                    n_ovf = 1'b1;
                end else begin
                    o_cmd.tri_wr = 1'b1;
                    n_count = r_count + 1'b1;
                end
                if (!r_fin) begin
                    n_state = ST_IDLE;
                end else begin
                    n_i = TW'(1);
                    n_state = ST_SORT_RD;
                end
            end
            ST_SORT_RD: begin
                // Outer pass i: bubble entry i down while its key is smaller.
                if (r_i >= r_count) begin
                    n_i = '0;
                    n_drop = r_ovf;
                    n_state = (r_count == '0) ? ST_IDLE : ST_EMIT_RD;
                    if (r_count == '0) begin
                        n_ovf = 1'b0;
                        n_fin = 1'b0;
                    end
                end else begin
                    n_j = r_i[TI-1:0];
                    n_state = ST_SORT_CMP;
                    o_cmd.sort_load = 1'b1;
                end
            end
            ST_SORT_CMP: begin
                if (i_stat.swap_needed) begin
                    n_state = ST_SORT_WR;
                end else begin
                    n_i = r_i + 1'b1;
                    n_state = ST_SORT_RD;
                end
            end
            ST_SORT_WR: begin
                o_cmd.sort_swap = 1'b1;
                if (r_j == TI'(1)) begin
                    n_i = r_i + 1'b1;
                    n_state = ST_SORT_RD;
                end else begin
                    n_j = r_j - 1'b1;
                    n_state = ST_SORT_CMP;
                end
            end
            ST_EMIT_RD: begin
                o_cmd.emit_load = 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                o_cmd.emit_show = 1'b1;
                n_valid = 1'b1;
                n_i = r_i + 1'b1;
                if (r_i + 1'b1 == r_count) begin
                    n_end = 1'b1;
                    n_count = '0;
                    n_ovf = 1'b0;
                    n_fin = 1'b0;
                    n_i = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The first pair of a pass is read at the pass index itself.
    assign o_busy     = (r_state != ST_IDLE);
    assign o_count    = r_count;
    assign o_sort_j   = (r_state == ST_SORT_RD) ? r_i[TI-1:0] : r_j;
    assign o_emit_idx = emit_pos[TI-1:0];
    assign o_valid    = r_valid;
    assign o_run_end  = r_end;
    assign o_dropped  = r_drop;
endmodule

@@ hdl/triangle_depth_sorter.sv @@
// Triangle depth sorter top level: registers, controller and datapath.
// A vertex word is written straight from idle; a triangle word keeps busy high while its key is computed and stored.
// The final triangle then runs an insertion sort over one store port, followed by
// the results, each read from the store before it is shown.
// Synchronous active-low reset clears the counters, the flags and the eye registers.
// Results are strobed for one cycle each; the receiver cannot stall.
`timescale 1ns / 1ps
module triangle_depth_sorter #(
    parameter int MAX_TRIANGLES = 64,
    parameter int MAX_VERTICES  = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_req_type,
    input  logic [7:0]         i_vertex_index,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic signed [15:0] i_pos_z,
    input  logic [7:0]         i_corner_a,
    input  logic [7:0]         i_corner_b,
    input  logic [7:0]         i_corner_c,
    input  logic               i_final_triangle,
    output logic               o_valid,
    output logic [7:0]         o_out_a,
    output logic [7:0]         o_out_b,
    output logic [7:0]         o_out_c,
    output logic               o_run_end,
    output logic               o_dropped
);
    import tds_pkg::*;

    localparam int TW = $clog2(MAX_TRIANGLES + 1);
    localparam int TI = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;

    logic signed [15:0] r_eye_x, r_eye_y, r_eye_z;
    logic               r_b2f;
    logic [7:0] r_vi, r_ca, r_cb, r_cc;
    logic signed [15:0] r_px, r_py, r_pz;
    t_cmd cmd;
    t_stat stat;
    logic [TW-1:0] count;
    logic [TI-1:0] sort_j, emit_idx;
    logic go;

    assign go = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eye_x <= '0;
            r_eye_y <= '0;
            r_eye_z <= '0;
            r_b2f   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_EYE_X: r_eye_x <= i_cfg_data;
                REG_EYE_Y: r_eye_y <= i_cfg_data;
                REG_EYE_Z: r_eye_z <= i_cfg_data;
                REG_B2F:   r_b2f   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // The triangle word is held for the duration of key computation.
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_ca <= i_corner_a;
            r_cb <= i_corner_b;
            r_cc <= i_corner_c;
        end
    end
    assign r_vi = i_vertex_index;
    assign r_px = i_pos_x;
    assign r_py = i_pos_y;
    assign r_pz = i_pos_z;

    tds_ctrl #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_req_type(i_req_type),
        .i_final(i_final_triangle), .i_b2f(r_b2f), .i_stat(stat), .o_cmd(cmd),
        .o_busy(busy), .o_count(count), .o_sort_j(sort_j), .o_emit_idx(emit_idx),
        .o_valid(o_valid), .o_run_end(o_run_end), .o_dropped(o_dropped)
    );

    tds_datapath #(.MAX_TRIANGLES(MAX_TRIANGLES), .MAX_VERTICES(MAX_VERTICES)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_vertex_index(r_vi),
        .i_pos_x(r_px), .i_pos_y(r_py), .i_pos_z(r_pz),
        .i_corner_a(r_ca), .i_corner_b(r_cb), .i_corner_c(r_cc),
        .i_eye_x(r_eye_x), .i_eye_y(r_eye_y), .i_eye_z(r_eye_z),
        .i_count(count), .i_sort_j(sort_j), .i_emit_idx(emit_idx),
        .o_stat(stat), .o_a(o_out_a), .o_b(o_out_b), .o_c(o_out_c)
    );
endmodule

@@ hdl/tds_checker.sv @@
// Port-level checks for the triangle depth sorter, bound to the top level.
// Depends on triangle_depth_sorter ports only.
`timescale 1ns / 1ps
module tds_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_req_type,
    input logic o_valid,
    input logic o_run_end
);
    // A run end only appears on a strobed word.
    a_end_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_run_end |-> o_valid) else $error("run end without word");

    // Apart from the last word of a run, words are never emitted while the block sits idle.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_run_end |-> busy) else $error("word while idle");

    // Emitted words are never back to back.
    a_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("back to back words");

    // Accepting a triangle word makes the block busy.
    a_tri_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req_type |=> busy) else $error("triangle not taken");

    // No word follows a reset cycle.
    a_quiet_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("word after reset");
endmodule

bind triangle_depth_sorter tds_checker u_tds_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
    .i_req_type(i_req_type), .o_valid(o_valid), .o_run_end(o_run_end)
);

@@ verif/triangle_depth_sorter_tb.sv @@
// Testbench for the triangle depth sorter: loads vertices, streams triangles and
// checks each sorted run against a predictor. Depends on tds_pkg and the top level.
`timescale 1ns / 1ps
module triangle_depth_sorter_tb;
    import tds_pkg::*;

    localparam int NTRI = 64;

    typedef struct {
        logic        req_type;
        logic [7:0]  vidx;
        logic [15:0] px, py, pz;
        logic [7:0]  ca, cb, cc;
        logic        fin;
    } t_word;

    typedef struct {
        logic [7:0] a, b, c;
        logic       run_end, dropped;
    } t_tri_out;

    typedef struct {
        logic [KEY_W-1:0] key;
        logic [7:0]       a, b, c;
    } t_tri_ent;

    logic        i_clk = 0, i_rst_n = 0, start = 0, busy;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = REG_EYE_X;
    logic [15:0] i_cfg_data = 0;
    logic        i_req_type = 0;
    logic [7:0]  i_vertex_index = 0;
    logic signed [15:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic [7:0]  i_corner_a = 0, i_corner_b = 0, i_corner_c = 0;
    logic        i_final_triangle = 0;
    logic        o_valid, o_run_end, o_dropped;
    logic [7:0]  o_out_a, o_out_b, o_out_c;

    triangle_depth_sorter uut (.*);

    initial forever #1 i_clk = ~i_clk;

    // Predictor state.
    logic signed [15:0] vtx_pos[256][3];
    bit          vtx_written[256];
    t_tri_ent    tri_mem[NTRI];
    int          tri_cnt = 0;
    bit          ovf = 0;
    logic signed [15:0] eye[3];
    bit          far_first = 0;

    t_word       pending_words[$];
    t_tri_out    sorted_expect[$];
    int          fails = 0, words_sent = 0, results_seen = 0, runs = 0;
    bit          cfg_hold = 0;

    task automatic report(string what);
        fails++;
        $display("mismatch @%0t: %s", $realtime, what);
    endtask

    function automatic logic [KEY_W-1:0] tri_depth_key(logic [7:0] a, b, c);
        logic [KEY_W-1:0] k;
        logic signed [20:0] d;
        k = 0;
        for (int ax = 0; ax < 3; ax++) begin
            d = 21'(vtx_pos[a][ax]) + 21'(vtx_pos[b][ax]) + 21'(vtx_pos[c][ax])
                - 21'(3) * 21'(eye[ax]);
            k += KEY_W'(42'(d) * 42'(d));
        end
        return k;
    endfunction

    task automatic predict_word(t_word w);
        int order[NTRI];
        int j, src;
        t_tri_out r;
        if (!w.req_type) begin
            vtx_pos[w.vidx][0] = w.px;
            vtx_pos[w.vidx][1] = w.py;
            vtx_pos[w.vidx][2] = w.pz;
            return;
        end
        if (tri_cnt < NTRI) begin
            tri_mem[tri_cnt] = '{tri_depth_key(w.ca, w.cb, w.cc), w.ca, w.cb, w.cc};
            tri_cnt++;
        end else ovf = 1;
        if (!w.fin) return;
        for (int i = 0; i < tri_cnt; i++) begin
            j = i;
            while (j > 0 && tri_mem[order[j-1]].key > tri_mem[i].key) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (int i = 0; i < tri_cnt; i++) begin
            src = far_first ? order[tri_cnt-1-i] : order[i];
            r.a = tri_mem[src].a; r.b = tri_mem[src].b; r.c = tri_mem[src].c;
            r.run_end = (i == tri_cnt - 1); r.dropped = ovf;
            sorted_expect.insert(sorted_expect.size(), r);
        end
        tri_cnt = 0; ovf = 0; runs++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 4);
        return $urandom_range(10, 60);
    endfunction

    task automatic drive_word();
        t_word w;
        w = pending_words.pop_front();
        predict_word(w);
        start <= 1;
        i_req_type <= w.req_type; i_vertex_index <= w.vidx;
        i_pos_x <= w.px; i_pos_y <= w.py; i_pos_z <= w.pz;
        i_corner_a <= w.ca; i_corner_b <= w.cb; i_corner_c <= w.cc;
        i_final_triangle <= w.fin;
    endtask

    // Driver: gap, then present the next word until accepted.
    int gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_hold) begin
            start <= 0;
        end else if (start && !busy) begin
            words_sent++;
            if (gap == 0 && pending_words.size() > 0 && $urandom_range(0, 3) != 0) begin
                drive_word();
            end else begin
                start <= 0;
                gap = pick_gap();
            end
        end else if (!start) begin
            if (gap > 0) gap--;
            else if (pending_words.size() > 0) drive_word();
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_tri_out e;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (sorted_expect.size() == 0) report("result with nothing expected");
            else begin
                e = sorted_expect.pop_front();
                if (o_out_a !== e.a) report($sformatf("out_a %0d exp %0d", o_out_a, e.a));
                if (o_out_b !== e.b) report($sformatf("out_b %0d exp %0d", o_out_b, e.b));
                if (o_out_c !== e.c) report($sformatf("out_c %0d exp %0d", o_out_c, e.c));
                if (o_run_end !== e.run_end) report("run_end wrong");
                if (o_dropped !== e.dropped) report("dropped wrong");
            end
        end
    end

    task automatic queue_word(bit rt, logic [7:0] vi, logic [15:0] x, y, z,
                              logic [7:0] a, b, c, bit f);
        t_word w;
        w = '{rt, vi, x, y, z, a, b, c, f};
        if (!rt) vtx_written[vi] = 1;
        pending_words.insert(pending_words.size(), w);
    endtask

    function automatic logic [7:0] any_written();
        logic [7:0] v;
        do v = 8'($urandom_range(0, 255)); while (!vtx_written[v]);
        return v;
    endfunction

    task automatic queue_tri(bit f);
        queue_word(1, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   any_written(), any_written(), any_written(), f);
    endtask

    task automatic queue_vtx();
        queue_word(0, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    endtask

    // Waits for the queued words and their results, plus sort slack.
    task automatic drain();
        while (pending_words.size() > 0 || start || busy || sorted_expect.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_index <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        if (idx == REG_B2F) far_first = val[0];
        else eye[idx] = val;
    endtask

    task automatic set_view(logic [15:0] x, y, z, bit b2f);
        cfg_hold = 1;
        cfg_write(REG_EYE_X, x); cfg_write(REG_EYE_Y, y);
        cfg_write(REG_EYE_Z, z); cfg_write(REG_B2F, {15'd0, b2f});
        cfg_hold = 0;
    endtask

    initial begin
        int n;
        eye[0] = 0; eye[1] = 0; eye[2] = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: extreme positions, ties, corners that pass the final flag on a vertex.
        set_view(16'h0000, 16'h0000, 16'h0000, 0);
        queue_word(0, 0, 16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 1);
        queue_word(0, 255, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'hFF, 8'hFF, 8'hFF, 0);
        queue_word(0, 1, 16'h0000, 16'h0000, 16'h0000, 0, 0, 0, 0);
        queue_word(1, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_word(1, 0, 0, 0, 0, 255, 255, 255, 0);
        queue_word(1, 0, 0, 0, 0, 1, 1, 1, 0);
        queue_word(1, 0, 0, 0, 0, 1, 1, 1, 0);
        queue_word(1, 0, 0, 0, 0, 0, 255, 1, 1);
        drain();
        set_view(16'h7FFF, 16'h8000, 16'h7FFF, 1);
        for (int i = 0; i < 4; i++) queue_word(1, 0, 0, 0, 0, 1, 0, 255, 0);
        queue_word(1, 0, 0, 0, 0, 255, 0, 1, 1);
        queue_word(1, 0, 0, 0, 0, 1, 1, 1, 1);
        drain();

        // Random phases; one overfills the store to exercise the drop flag.
        for (int ph = 0; ph < 6; ph++) begin
            set_view(16'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom_range(0, 1)));
            n = 0;
            while (n < 60) begin
                if ($urandom_range(0, 3) == 0) queue_vtx();
                else if (ph == 3 && n < 55) begin
                    for (int k = 0; k < 66; k++) queue_tri(0);
                    queue_tri(1);
                    n += 67;
                end else begin
                    int len;
                    len = $urandom_range(1, 12);
                    for (int k = 0; k < len; k++) queue_tri(k == len - 1);
                    n += len;
                end
                n++;
            end
            drain();
        end
        $display("Covered %0d words over %0d sorted runs, %0d triangles emitted.",
                 words_sent, runs, results_seen);
        if (fails == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
